// ----- hdl/tle_pkg.sv -----
`timescale 1ns / 1ps
// Package for the terminal line editor: sizes, key and command codes,
// queue op and status types. Has no dependencies.
package tle_pkg;

  localparam int LINE_BYTES = 64;
  localparam int LINE_AW    = $clog2(LINE_BYTES);
  localparam int Q_DEPTH    = 2;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [1:0] CMD_RECV  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] KEY_ESC     = 8'h1B;
  localparam logic [7:0] KEY_CR      = 8'h0D;
  localparam logic [7:0] KEY_LF      = 8'h0A;
  localparam logic [7:0] KEY_BRACKET = 8'h5B;
  localparam logic [7:0] KEY_RIGHT   = 8'h43;
  localparam logic [7:0] KEY_LEFT    = 8'h44;
  localparam logic [7:0] BACKSPACE_RESET = 8'd127;

  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_INSERT = 3'd1;
  localparam logic [2:0] OP_DELETE = 3'd2;
  localparam logic [2:0] OP_RIGHT  = 3'd3;
  localparam logic [2:0] OP_LEFT   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;
  localparam logic [2:0] OP_CLEAR  = 3'd6;

  typedef logic [LINE_AW-1:0] pos_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] ch;
    logic [5:0] idx;
    logic       done;
    logic       bad;
  } op_t;

  typedef struct packed {
    pos_t len;
    pos_t cur;
  } bk_status_t;

endpackage

// ----- hdl/tle_ifs.sv -----
`timescale 1ns / 1ps
// Word channel interfaces of the terminal line editor: input commands and
// results. Valid/ready handshake; no dependencies.
interface tle_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;
  logic [5:0] read_index;
  modport source(output valid, cmd, data_byte, read_index, input ready);
  modport sink(input valid, cmd, data_byte, read_index, output ready);
endinterface

interface tle_out_if;
  logic       valid;
  logic       ready;
  logic       line_done;
  logic       bad_escape;
  logic [7:0] read_char;
  logic [5:0] line_length;
  logic [5:0] cursor_pos;
  modport source(output valid, line_done, bad_escape, read_char, line_length, cursor_pos,
                 input ready);
  modport sink(input valid, line_done, bad_escape, read_char, line_length, cursor_pos,
               output ready);
endinterface

// ----- hdl/terminal_line_editor.sv -----
`timescale 1ns / 1ps
// Top level of the terminal line editor: APB register, front end, op queue
// and back end. Uses tle_pkg, tle_ifs, tle_front, tle_queue and tle_back.
//
// Each input word becomes one result word. Reads, clears, cursor moves,
// CR, LF, escape bytes and inserts or deletes at the end of the line need
// no shifting in the back end; an insert or a delete elsewhere shifts the
// characters behind the cursor, and the line memory, with one read port
// and one write port, moves one character per cycle. A two-word queue
// lets the input side keep accepting while the back end shifts or a result
// waits to be taken. No clearing pass is needed after reset.
module terminal_line_editor (
  input  logic        clk,
  input  logic        rst,
  tle_in_if.sink      in_ch,
  tle_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] ADDR_BACKSPACE = 3'd0;

  logic                backspace_code;
  logic [7:0]          bs_code;
  tle_pkg::op_t        push_op;
  logic                push_valid;
  logic                push_ready;
  tle_pkg::op_t        pop_op;
  logic                pop_valid;
  logic                pop_ready;
  tle_pkg::bk_status_t st;

  assign pready         = 1'b1;
  assign backspace_code = psel && penable && pwrite && pready && (paddr == ADDR_BACKSPACE);
  assign prdata         = (paddr == ADDR_BACKSPACE) ? {24'd0, bs_code} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      bs_code <= tle_pkg::BACKSPACE_RESET;
    end else if (backspace_code) begin
      bs_code <= pwdata[7:0];
    end
  end

  tle_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .backspace_code (bs_code),
    .push_op        (push_op),
    .push_valid     (push_valid),
    .push_ready     (push_ready)
  );

  tle_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_op    (push_op),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_op     (pop_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  tle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_op    (pop_op),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .out_ch    (out_ch),
    .status    (st)
  );

  a_cursor_in_line: assert property (@(posedge clk) disable iff (rst)
    st.cur <= st.len)
    else $error("Cursor is beyond the line length.");

  a_length_limit: assert property (@(posedge clk) disable iff (rst)
    st.len <= tle_pkg::pos_t'(tle_pkg::LINE_BYTES - 1))
    else $error("Line length exceeds the buffer.");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.line_done && out_ch.bad_escape) &&
                     (out_ch.cursor_pos <= out_ch.line_length))
    else $error("Result word is inconsistent.");

endmodule

// ----- hdl/tle_front.sv -----
`timescale 1ns / 1ps
// Front end of the terminal line editor: accepts words, tracks escape
// sequences and turns each word into one edit op. Uses tle_pkg and tle_in_if.
module tle_front (
  input  logic              clk,
  input  logic              rst,
  tle_in_if.sink            in_ch,
  input  logic [7:0]        backspace_code,
  output tle_pkg::op_t      push_op,
  output logic              push_valid,
  input  logic              push_ready
);

  logic escaping;
  logic escape_step;
  logic escaping_next;
  logic escape_step_next;
  tle_pkg::op_t op;

  always_comb begin
    op               = '0;
    op.kind          = tle_pkg::OP_NOP;
    op.ch            = in_ch.data_byte;
    op.idx           = in_ch.read_index;
    escaping_next    = escaping;
    escape_step_next = escape_step;
    case (in_ch.cmd)
      tle_pkg::CMD_RECV: begin
        if (escaping) begin
          if (!escape_step) begin
            if (in_ch.data_byte == tle_pkg::KEY_BRACKET) begin
              escape_step_next = 1'b1;
            end else begin
              op.bad        = 1'b1;
              escaping_next = 1'b0;
            end
          end else begin
            if (in_ch.data_byte == tle_pkg::KEY_RIGHT) begin
              op.kind = tle_pkg::OP_RIGHT;
            end else if (in_ch.data_byte == tle_pkg::KEY_LEFT) begin
              op.kind = tle_pkg::OP_LEFT;
            end else begin
              op.bad = 1'b1;
            end
            escaping_next    = 1'b0;
            escape_step_next = 1'b0;
          end
        end else if (in_ch.data_byte == tle_pkg::KEY_ESC) begin
          escaping_next    = 1'b1;
          escape_step_next = 1'b0;
        end else if (in_ch.data_byte == tle_pkg::KEY_CR) begin
          op.kind = tle_pkg::OP_NOP;
        end else if (in_ch.data_byte == tle_pkg::KEY_LF) begin
          op.done = 1'b1;
        end else if (in_ch.data_byte == backspace_code) begin
          op.kind = tle_pkg::OP_DELETE;
        end else begin
          op.kind = tle_pkg::OP_INSERT;
        end
      end
      tle_pkg::CMD_READ: begin
        op.kind = tle_pkg::OP_READ;
      end
      tle_pkg::CMD_CLEAR: begin
        op.kind          = tle_pkg::OP_CLEAR;
        escaping_next    = 1'b0;
        escape_step_next = 1'b0;
      end
      default: begin
        op.kind = tle_pkg::OP_NOP;
      end
    endcase
  end

  assign push_op     = op;
  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      escaping    <= 1'b0;
      escape_step <= 1'b0;
    end else if (in_ch.valid && push_ready) begin
      escaping    <= escaping_next;
      escape_step <= escape_step_next;
    end
  end

endmodule

// ----- hdl/tle_queue.sv -----
`timescale 1ns / 1ps
// Short op queue between the front and back ends of the terminal line
// editor. Uses tle_pkg.
module tle_queue (
  input  logic         clk,
  input  logic         rst,
  input  tle_pkg::op_t push_op,
  input  logic         push_valid,
  output logic         push_ready,
  output tle_pkg::op_t pop_op,
  output logic         pop_valid,
  input  logic         pop_ready
);

  tle_pkg::op_t            slots [tle_pkg::Q_DEPTH];
  logic [tle_pkg::Q_AW-1:0] wr_ptr;
  logic [tle_pkg::Q_AW-1:0] rd_ptr;
  logic [tle_pkg::Q_AW:0]   count;
  logic                     do_push;
  logic                     do_pop;

  assign push_ready = (count != (tle_pkg::Q_AW + 1)'(tle_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_op     = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tle_back.sv -----
`timescale 1ns / 1ps
// Back end of the terminal line editor: line memory, length and cursor,
// the character shift sequencer and the result register. Uses tle_pkg, tle_out_if.
module tle_back (
  input  logic                clk,
  input  logic                rst,
  input  tle_pkg::op_t        pop_op,
  input  logic                pop_valid,
  output logic                pop_ready,
  tle_out_if.source           out_ch,
  output tle_pkg::bk_status_t status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOVE   = 3'd1;
  localparam logic [2:0] S_LAST   = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_REPORT = 3'd4;

  localparam tle_pkg::pos_t ONE  = tle_pkg::pos_t'(1);
  localparam tle_pkg::pos_t FULL = tle_pkg::pos_t'(tle_pkg::LINE_BYTES - 1);

  logic [2:0]    state;
  tle_pkg::pos_t len;
  tle_pkg::pos_t cur;
  tle_pkg::op_t  op;
  tle_pkg::pos_t src;
  tle_pkg::pos_t cnt;
  tle_pkg::pos_t wr_addr;
  logic          wr_pend;
  logic          mov_up;

  logic [7:0]    mem [tle_pkg::LINE_BYTES];
  logic [7:0]    rdata;
  logic          re;
  logic          we;
  tle_pkg::pos_t raddr;
  tle_pkg::pos_t waddr;
  logic [7:0]    wdata;

  logic          res_valid;
  logic          res_done;
  logic          res_bad;
  logic [7:0]    res_char;
  logic [5:0]    res_len;
  logic [5:0]    res_cur;

  assign pop_ready = (state == S_IDLE);

  always_comb begin
    re    = 1'b0;
    raddr = src;
    we    = 1'b0;
    waddr = wr_addr;
    wdata = rdata;
    case (state)
      S_IDLE: begin
        if (pop_valid && pop_op.kind == tle_pkg::OP_READ) begin
          re    = 1'b1;
          raddr = tle_pkg::pos_t'(pop_op.idx);
        end
        if (pop_valid && pop_op.kind == tle_pkg::OP_INSERT && len != FULL && cur == len) begin
          we    = 1'b1;
          waddr = cur;
          wdata = pop_op.ch;
        end
      end
      S_MOVE: begin
        re = 1'b1;
        we = wr_pend;
      end
      S_LAST: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = cur;
        wdata = op.ch;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      cur       <= '0;
      wr_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (state == S_REPORT && (!res_valid || out_ch.ready)) begin
        res_valid <= 1'b1;
      end else if (out_ch.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop_valid) begin
            op      <= pop_op;
            wr_pend <= 1'b0;
            state   <= S_REPORT;
            case (pop_op.kind)
              tle_pkg::OP_RIGHT: begin
                if (cur < len) begin
                  cur <= cur + ONE;
                end
              end
              tle_pkg::OP_LEFT: begin
                if (cur != '0) begin
                  cur <= cur - ONE;
                end
              end
              tle_pkg::OP_CLEAR: begin
                len <= '0;
                cur <= '0;
              end
              tle_pkg::OP_INSERT: begin
                if (len != FULL) begin
                  if (cur == len) begin
                    len <= len + ONE;
                    cur <= cur + ONE;
                  end else begin
                    src    <= len - ONE;
                    cnt    <= len - cur;
                    mov_up <= 1'b0;
                    state  <= S_MOVE;
                  end
                end
              end
              tle_pkg::OP_DELETE: begin
                if (cur < len) begin
                  len <= len - ONE;
                  if (len - cur != ONE) begin
                    src    <= cur + ONE;
                    cnt    <= len - cur - ONE;
                    mov_up <= 1'b1;
                    state  <= S_MOVE;
                  end
                end
              end
              default: begin
                state <= S_REPORT;
              end
            endcase
          end
        end
        S_MOVE: begin
          wr_pend <= 1'b1;
          wr_addr <= mov_up ? src - ONE : src + ONE;
          src     <= mov_up ? src + ONE : src - ONE;
          cnt     <= cnt - ONE;
          if (cnt == ONE) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          state <= mov_up ? S_REPORT : S_PUT;
        end
        S_PUT: begin
          len   <= len + ONE;
          cur   <= cur + ONE;
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (!res_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_REPORT && (!res_valid || out_ch.ready)) begin
      res_done <= op.done;
      res_bad  <= op.bad;
      res_char <= (op.kind == tle_pkg::OP_READ && 9'(op.idx) < 9'(len)) ? rdata : 8'd0;
      res_len  <= 6'(len);
      res_cur  <= 6'(cur);
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.line_done   = res_done;
  assign out_ch.bad_escape  = res_bad;
  assign out_ch.read_char   = res_char;
  assign out_ch.line_length = res_len;
  assign out_ch.cursor_pos  = res_cur;

  assign status.len = len;
  assign status.cur = cur;

endmodule

// ----- dv/tb_terminal_line_editor.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for terminal_line_editor: drives command words and
// backspace settings, predicts each result word and compares it on arrival.
// Depends on tle_pkg, tle_ifs and the terminal_line_editor RTL.
module tb_terminal_line_editor;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          RANDOM_WORDS  = 300;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [2:0]  REG_BACKSPACE = 3'd0;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic       done;
    logic       bad;
    logic [7:0] rd;
    logic [5:0] len;
    logic [5:0] cur;
  } line_status_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tle_in_if  in_ch();
  tle_out_if out_ch();

  terminal_line_editor dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [7:0]   shadow_line [tle_pkg::LINE_BYTES];
  int           shadow_len;
  int           shadow_cur;
  logic         shadow_esc;
  logic [1:0]   shadow_step;
  logic [7:0]   shadow_bs;
  line_status_t pending_status[$];
  idle_mode_t   idle_mode = IDLE_NONE;
  int           cycle_count = 0;
  int           words_sent = 0;
  int           words_checked = 0;
  int           mismatches = 0;
  int           full_drops = 0;
  int           bad_escapes = 0;
  int           bs_settings = 0;

  always #2 clk = ~clk;

  function automatic void clear_shadow();
    foreach (shadow_line[i]) shadow_line[i] = 8'h00;
    shadow_len  = 0;
    shadow_cur  = 0;
    shadow_esc  = 1'b0;
    shadow_step = 2'd0;
  endfunction

  function automatic line_status_t edit_line(logic [1:0] c, logic [7:0] b, logic [5:0] ix);
    line_status_t r;
    r = '0;
    case (c)
      tle_pkg::CMD_RECV: begin
        if (shadow_esc) begin
          shadow_step = shadow_step + 2'd1;
          if (shadow_step == 2'd1) begin
            if (b != tle_pkg::KEY_BRACKET) begin
              r.bad       = 1'b1;
              shadow_esc  = 1'b0;
              shadow_step = 2'd0;
            end
          end else begin
            if (b == tle_pkg::KEY_RIGHT) begin
              if (shadow_cur < shadow_len) shadow_cur++;
            end else if (b == tle_pkg::KEY_LEFT) begin
              if (shadow_cur > 0) shadow_cur--;
            end else begin
              r.bad = 1'b1;
            end
            shadow_esc  = 1'b0;
            shadow_step = 2'd0;
          end
        end else if (b == tle_pkg::KEY_ESC) begin
          shadow_esc  = 1'b1;
          shadow_step = 2'd0;
        end else if (b == tle_pkg::KEY_LF) begin
          r.done = 1'b1;
        end else if (b != tle_pkg::KEY_CR) begin
          if (b == shadow_bs) begin
            if (shadow_cur < shadow_len) begin
              for (int i = shadow_cur; i + 1 < shadow_len; i++) shadow_line[i] = shadow_line[i + 1];
              shadow_line[shadow_len - 1] = 8'h00;
              shadow_len--;
            end
          end else if (shadow_len + 1 < tle_pkg::LINE_BYTES) begin
            for (int i = shadow_len; i > shadow_cur; i--) shadow_line[i] = shadow_line[i - 1];
            shadow_line[shadow_cur] = b;
            shadow_len++;
            shadow_cur++;
          end else begin
            full_drops++;
          end
        end
      end
      tle_pkg::CMD_READ: begin
        if (int'(ix) < shadow_len) r.rd = shadow_line[ix];
      end
      tle_pkg::CMD_CLEAR: clear_shadow();
      default: ;
    endcase
    if (r.bad) bad_escapes++;
    r.len = shadow_len[5:0];
    r.cur = shadow_cur[5:0];
    return r;
  endfunction

  task automatic send_word(input logic [1:0] c, input logic [7:0] b, input logic [5:0] ix);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 73 : (idle_mode == IDLE_BOTH) ? 8 : 0;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_ch.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_ch.valid      = 1'b1;
    in_ch.cmd        = c;
    in_ch.data_byte  = b;
    in_ch.read_index = ix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_status.push_back(edit_line(c, b, ix));
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_word(tle_pkg::CMD_RECV, b, 6'($urandom));
  endtask

  task automatic send_escape(input logic [7:0] fin_byte);
    send_byte(tle_pkg::KEY_ESC);
    send_byte(tle_pkg::KEY_BRACKET);
    send_byte(fin_byte);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_backspace(input logic [7:0] code);
    wait_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = REG_BACKSPACE;
    pwdata  = {24'h0, code};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_bs = code;
    bs_settings++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ch.ready = ($urandom_range(99) >= 73);
      IDLE_BOTH:     out_ch.ready = ($urandom_range(99) >= 8);
      default:       out_ch.ready = 1'b1;
    endcase
  end

  always @(posedge clk) begin
    line_status_t got;
    line_status_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.line_done, out_ch.bad_escape, out_ch.read_char,
             out_ch.line_length, out_ch.cursor_pos};
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result word with nothing pending: %p", got);
      end else begin
        want = pending_status.pop_front();
        words_checked++;
        if (got.done !== want.done || got.bad !== want.bad || got.rd !== want.rd ||
            got.len !== want.len || got.cur !== want.cur) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at word %0d: expected %p, got %p", words_checked, want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(tle_pkg::CMD_READ, 8'hFF, 6'd0);
    send_byte(tle_pkg::BACKSPACE_RESET);
    send_escape(tle_pkg::KEY_LEFT);
    send_byte(8'h41);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(tle_pkg::KEY_CR);
    send_byte(tle_pkg::KEY_LF);
    send_escape(tle_pkg::KEY_RIGHT);
    send_escape(tle_pkg::KEY_LEFT);
    send_escape(tle_pkg::KEY_LEFT);
    send_byte(tle_pkg::BACKSPACE_RESET);
    send_word(tle_pkg::CMD_READ, 8'h00, 6'd1);
    send_word(tle_pkg::CMD_READ, 8'h00, 6'd63);
    send_byte(tle_pkg::KEY_ESC);
    send_byte(8'h78);
    send_escape(8'h5A);
    send_word(CMD_UNUSED, 8'hFF, 6'd63);
    send_byte(tle_pkg::KEY_ESC);
    send_word(tle_pkg::CMD_CLEAR, 8'h00, 6'd0);
    send_word(tle_pkg::CMD_READ, 8'h00, 6'd0);
  endtask

  task automatic test_backspace_collision();
    write_backspace(tle_pkg::KEY_LF);
    send_byte(8'h31);
    send_byte(tle_pkg::KEY_LF);
    write_backspace(tle_pkg::KEY_ESC);
    send_escape(tle_pkg::KEY_LEFT);
    write_backspace(tle_pkg::KEY_BRACKET);
    send_escape(tle_pkg::KEY_RIGHT);
    send_escape(tle_pkg::KEY_LEFT);
    send_byte(tle_pkg::KEY_BRACKET);
    write_backspace(8'h00);
    send_byte(8'h32);
    send_escape(tle_pkg::KEY_LEFT);
    send_byte(8'h00);
    write_backspace(8'hFF);
    send_byte(8'hFF);
    send_word(tle_pkg::CMD_CLEAR, 8'h00, 6'd0);
  endtask

  task automatic test_full_line();
    logic [7:0] b;
    write_backspace(tle_pkg::BACKSPACE_RESET);
    for (int i = 0; i < tle_pkg::LINE_BYTES + 2; i++) begin
      b = 8'($urandom_range(8'h20, 8'h7E));
      if (b == tle_pkg::BACKSPACE_RESET || b == tle_pkg::KEY_BRACKET) b = 8'h61;
      send_byte(b);
    end
    for (int i = 0; i < tle_pkg::LINE_BYTES; i++) send_word(tle_pkg::CMD_READ, 8'h00, 6'(i));
    send_escape(tle_pkg::KEY_RIGHT);
    repeat (5) send_escape(tle_pkg::KEY_LEFT);
    send_byte(8'h7A);
    send_byte(tle_pkg::BACKSPACE_RESET);
    send_byte(8'h7A);
    send_escape(tle_pkg::KEY_LEFT);
    send_byte(tle_pkg::BACKSPACE_RESET);
    send_word(tle_pkg::CMD_CLEAR, 8'h00, 6'd0);
  endtask

  task automatic send_random_item();
    int         pick;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick < 34) begin
      b = 8'($urandom);
      if (b == tle_pkg::KEY_ESC || b == tle_pkg::KEY_CR || b == tle_pkg::KEY_LF ||
          b == shadow_bs)
        b = 8'($urandom_range(8'h20, 8'h5A));
      if (b == shadow_bs) b = b ^ 8'h01;
      send_byte(b);
    end else if (pick < 52) begin
      send_byte(shadow_bs);
    end else if (pick < 66) begin
      send_escape($urandom_range(1) ? tle_pkg::KEY_RIGHT : tle_pkg::KEY_LEFT);
    end else if (pick < 71) begin
      send_byte(tle_pkg::KEY_ESC);
      if ($urandom_range(1)) send_byte(tle_pkg::KEY_BRACKET);
      send_byte(8'($urandom));
    end else if (pick < 82) begin
      if ($urandom_range(1))
        send_word(tle_pkg::CMD_READ, 8'($urandom), 6'($urandom_range(shadow_len)));
      else send_word(tle_pkg::CMD_READ, 8'($urandom), 6'($urandom));
    end else if (pick < 86) begin
      send_byte($urandom_range(1) ? tle_pkg::KEY_CR : tle_pkg::KEY_LF);
    end else if (pick < 89) begin
      send_word(tle_pkg::CMD_CLEAR, 8'($urandom), 6'($urandom));
    end else if (pick < 91) begin
      send_word(CMD_UNUSED, 8'($urandom), 6'($urandom));
    end else begin
      send_word(2'($urandom), 8'($urandom), 6'($urandom));
    end
  endtask

  task automatic test_random(input idle_mode_t mode, input logic [7:0] code);
    int target;
    write_backspace(code);
    idle_mode = mode;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      send_random_item();
      if ($urandom_range(99) == 0) wait_idle();
    end
    wait_idle();
    idle_mode = IDLE_NONE;
  endtask

  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = tle_pkg::CMD_RECV;
    in_ch.data_byte  = 8'h00;
    in_ch.read_index = 6'd0;
    clear_shadow();
    shadow_bs = tle_pkg::BACKSPACE_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_backspace_collision();
    test_full_line();
    test_random(IDLE_NONE, 8'h08);
    test_random(IDLE_SENDER, tle_pkg::BACKSPACE_RESET);
    test_random(IDLE_RECEIVER, 8'($urandom));
    test_random(IDLE_BOTH, 8'h00);

    wait_idle();
    repeat (80) @(posedge clk);
    $display("Sent %0d command words and checked %0d result words over %0d backspace settings",
             words_sent, words_checked, bs_settings);
    $display("Saw %0d inserts dropped on a full line and %0d rejected escapes; %0d mismatches",
             full_drops, bad_escapes, mismatches);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
